// ===== hw/rtl/ptd_pkg.sv =====
// Package with the shared types and constants of the priority task dispatcher.
package ptd_pkg;

	// Slot counts of the three task classes.
	localparam int SYS_SLOTS = 4;
	localparam int RR_SLOTS  = 4;
	localparam int PER_SLOTS = 8;

	// Index widths follow from the slot counts.
	localparam int SYS_IW = (SYS_SLOTS > 1) ? $clog2(SYS_SLOTS) : 1;
	localparam int RR_IW  = (RR_SLOTS > 1) ? $clog2(RR_SLOTS) : 1;
	localparam int PER_IW = (PER_SLOTS > 1) ? $clog2(PER_SLOTS) : 1;
	localparam int SLOT_W = (SYS_IW > RR_IW) ? ((SYS_IW > PER_IW) ? SYS_IW : PER_IW)
		: ((RR_IW > PER_IW) ? RR_IW : PER_IW);
	localparam int CNT_W  = 4;

	// Event codes.
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_YIELD     = 3'd1;
	localparam logic [2:0] OP_TERMINATE = 3'd2;
	localparam logic [2:0] OP_BLOCK     = 3'd3;
	localparam logic [2:0] OP_CREATE    = 3'd4;

	// Class codes.
	localparam logic [1:0] CL_IDLE = 2'd0;
	localparam logic [1:0] CL_RR   = 2'd1;
	localparam logic [1:0] CL_PER  = 2'd2;
	localparam logic [1:0] CL_SYS  = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_WCET = 2'd2;

	typedef enum logic [2:0] {
		ST_DEAD      = 3'd0,
		ST_READY     = 3'd1,
		ST_RUNNING   = 3'd2,
		ST_SUSPENDED = 3'd3,
		ST_BLOCKED   = 3'd4
	} slot_st_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SYS,
		FSM_PRD_RD,
		FSM_PRD_EX,
		FSM_RR,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  task_class;
		logic [15:0] period;
		logic [15:0] wcet;
		logic [14:0] offset;
	} req_t;

	typedef struct packed {
		logic [1:0] run_class;
		logic [2:0] run_slot;
		logic [1:0] error_code;
		logic [2:0] created_slot;
	} rsp_t;

	// One periodic task record as kept in the record memory.
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] wcet;
		logic [16:0] countdown;
		logic [15:0] last_check;
		logic [15:0] run_ticks;
	} prd_rec_t;

endpackage

// ===== hw/rtl/ptd_pmem.sv =====
// Periodic task record memory: one write port, one registered read port.
module ptd_pmem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ptd_pkg::PER_IW-1:0] waddr,
	input  ptd_pkg::prd_rec_t         wdata,
	input  logic                      re,
	input  logic [ptd_pkg::PER_IW-1:0] raddr,
	output ptd_pkg::prd_rec_t         rdata
);

	ptd_pkg::prd_rec_t mem [ptd_pkg::PER_SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/priority_task_dispatcher_core.sv =====
// Top level of the priority task dispatcher: slot states, scan sequencer and result register.
//
// Usage: kernel events enter on the req channel (req_valid, req_stall, req) and each
// event gives exactly one result on the rsp channel (rsp_valid, rsp_stall, rsp).
// A transfer happens at a rising edge with valid high and stall low.
// A create or an unused code goes from the sequencer straight to the result register.
// A tick, yield, terminate or block runs a dispatch scan that stops at the first task
// it takes: each system slot in turn, each live periodic slot by a record memory read
// and then an age and write back, each other periodic slot and each round-robin slot
// in turn, and then the result register is loaded.
// One event is in work at a time; req_stall is high while an event is in work.
// A new event is taken while the previous result waits to be transferred; its own
// result waits in the sequencer until the result register is free.
// Reset (arst_n low) marks all slots dead, clears time, pointers and the current
// task to idle. The periodic records hold no reset value and are written on create.
module priority_task_dispatcher_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ptd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ptd_pkg::rsp_t rsp
);

	ptd_pkg::fsm_t     state_q, state_d;
	ptd_pkg::slot_st_t sys_st_q [ptd_pkg::SYS_SLOTS];
	ptd_pkg::slot_st_t rr_st_q  [ptd_pkg::RR_SLOTS];
	ptd_pkg::slot_st_t per_st_q [ptd_pkg::PER_SLOTS];

	logic [15:0]                 time_q;
	logic [ptd_pkg::SYS_IW-1:0]  sys_ptr_q;
	logic [ptd_pkg::PER_IW-1:0]  per_ptr_q;
	logic [ptd_pkg::RR_IW-1:0]   rr_ptr_q;
	logic [1:0]                  cur_class_q;
	logic [ptd_pkg::SLOT_W-1:0]  cur_slot_q;
	logic [ptd_pkg::CNT_W-1:0]   cnt_q;
	logic [1:0]                  err_q;
	logic [2:0]                  created_q;
	logic                        rsp_valid_q;
	ptd_pkg::rsp_t               rsp_q;

	logic                        acc;
	logic                        rsp_load;
	logic                        sys_hit, rr_hit, per_live, per_take, rel;
	logic                        sys_last, per_last, rr_last;
	ptd_pkg::slot_st_t           per_st_p;
	ptd_pkg::slot_st_t           cur_st;
	ptd_pkg::slot_st_t           cur_new;
	logic                        cur_upd;
	logic [ptd_pkg::SYS_IW-1:0]  sys_ptr_nx;
	logic [ptd_pkg::PER_IW-1:0]  per_ptr_nx;
	logic [ptd_pkg::RR_IW-1:0]   rr_ptr_nx;

	// Record memory signals and aging arithmetic.
	logic                        mem_we, mem_re;
	logic [ptd_pkg::PER_IW-1:0]  mem_waddr;
	ptd_pkg::prd_rec_t           mem_wdata, mem_rdata, rec_aged;
	logic [15:0]                 delta;
	logic [17:0]                 cd_sub;
	logic [16:0]                 cd_aged;
	logic [16:0]                 run_sum;

	// Free slot search for create.
	logic                        dead_found;
	logic [ptd_pkg::SLOT_W-1:0]  dead_idx;
	logic                        cr_per;

	logic [ptd_pkg::SYS_SLOTS+ptd_pkg::RR_SLOTS+ptd_pkg::PER_SLOTS-1:0] run_vec;

	ptd_pmem u_pmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (per_ptr_q),
		.rdata (mem_rdata)
	);

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != ptd_pkg::FSM_IDLE);
	assign rsp_load  = (state_q == ptd_pkg::FSM_OUT) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Scan positions and wrap-around pointers.
	assign sys_hit  = (sys_st_q[sys_ptr_q] == ptd_pkg::ST_READY);
	assign rr_hit   = (rr_st_q[rr_ptr_q] == ptd_pkg::ST_READY);
	assign per_st_p = per_st_q[per_ptr_q];
	assign per_live = (per_st_p == ptd_pkg::ST_READY) || (per_st_p == ptd_pkg::ST_SUSPENDED);
	assign sys_last = (cnt_q == ptd_pkg::CNT_W'(ptd_pkg::SYS_SLOTS - 1));
	assign per_last = (cnt_q == ptd_pkg::CNT_W'(ptd_pkg::PER_SLOTS - 1));
	assign rr_last  = (cnt_q == ptd_pkg::CNT_W'(ptd_pkg::RR_SLOTS - 1));
	assign sys_ptr_nx = (sys_ptr_q == ptd_pkg::SYS_IW'(ptd_pkg::SYS_SLOTS - 1)) ? '0
		: sys_ptr_q + 1'b1;
	assign per_ptr_nx = (per_ptr_q == ptd_pkg::PER_IW'(ptd_pkg::PER_SLOTS - 1)) ? '0
		: per_ptr_q + 1'b1;
	assign rr_ptr_nx = (rr_ptr_q == ptd_pkg::RR_IW'(ptd_pkg::RR_SLOTS - 1)) ? '0
		: rr_ptr_q + 1'b1;

	// Age the record read from memory by the ticks since its last check.
	assign delta   = time_q - mem_rdata.last_check;
	assign cd_sub  = {mem_rdata.countdown[16], mem_rdata.countdown} - {2'b00, delta};
	assign cd_aged = ($signed(cd_sub) < -18'sd65536) ? 17'h10000 : cd_sub[16:0];
	assign run_sum = {1'b0, mem_rdata.run_ticks} + {1'b0, delta};
	assign rel     = cd_aged[16] || (cd_aged == '0);
	assign per_take = (per_st_p == ptd_pkg::ST_READY) || rel;

	always_comb begin
		rec_aged            = mem_rdata;
		rec_aged.countdown  = cd_aged;
		rec_aged.last_check = time_q;
		rec_aged.run_ticks  = run_sum[16] ? 16'hFFFF : run_sum[15:0];
	end

	// First dead slot of the class named by a create.
	always_comb begin
		dead_found = 1'b0;
		dead_idx   = '0;
		case (req.task_class)
			ptd_pkg::CL_SYS: begin
				for (int i = ptd_pkg::SYS_SLOTS - 1; i >= 0; i--) begin
					if (sys_st_q[i] == ptd_pkg::ST_DEAD) begin
						dead_found = 1'b1;
						dead_idx   = ptd_pkg::SLOT_W'(i);
					end
				end
			end
			ptd_pkg::CL_PER: begin
				for (int i = ptd_pkg::PER_SLOTS - 1; i >= 0; i--) begin
					if (per_st_q[i] == ptd_pkg::ST_DEAD) begin
						dead_found = 1'b1;
						dead_idx   = ptd_pkg::SLOT_W'(i);
					end
				end
			end
			ptd_pkg::CL_RR: begin
				for (int i = ptd_pkg::RR_SLOTS - 1; i >= 0; i--) begin
					if (rr_st_q[i] == ptd_pkg::ST_DEAD) begin
						dead_found = 1'b1;
						dead_idx   = ptd_pkg::SLOT_W'(i);
					end
				end
			end
			default: begin
				dead_found = 1'b0;
			end
		endcase
	end

	assign cr_per = acc && (req.op == ptd_pkg::OP_CREATE) && (req.task_class == ptd_pkg::CL_PER)
		&& dead_found;

	// Memory port control: create writes a fresh record, the periodic scan writes back.
	always_comb begin
		mem_re    = (state_q == ptd_pkg::FSM_PRD_RD) && per_live;
		mem_we    = 1'b0;
		mem_waddr = per_ptr_q;
		mem_wdata = rec_aged;
		if (cr_per) begin
			mem_we    = 1'b1;
			mem_waddr = dead_idx[ptd_pkg::PER_IW-1:0];
			mem_wdata = '{period: req.period, wcet: req.wcet,
				countdown: {2'b00, req.offset}, last_check: time_q, run_ticks: 16'd0};
		end else if (state_q == ptd_pkg::FSM_PRD_EX) begin
			mem_we = 1'b1;
			if (per_st_p == ptd_pkg::ST_SUSPENDED && rel) begin
				mem_wdata.countdown = {1'b0, mem_rdata.period};
				mem_wdata.run_ticks = 16'd1;
			end
		end
	end

	// State change of the current task for the event taken.
	always_comb begin
		case (cur_class_q)
			ptd_pkg::CL_SYS: cur_st = sys_st_q[cur_slot_q[ptd_pkg::SYS_IW-1:0]];
			ptd_pkg::CL_PER: cur_st = per_st_q[cur_slot_q[ptd_pkg::PER_IW-1:0]];
			ptd_pkg::CL_RR:  cur_st = rr_st_q[cur_slot_q[ptd_pkg::RR_IW-1:0]];
			default:         cur_st = ptd_pkg::ST_DEAD;
		endcase
		cur_upd = acc && (cur_class_q != ptd_pkg::CL_IDLE);
		case (req.op)
			ptd_pkg::OP_TICK: begin
				cur_new = ptd_pkg::ST_READY;
				cur_upd = cur_upd && (cur_st == ptd_pkg::ST_RUNNING);
			end
			ptd_pkg::OP_YIELD: begin
				cur_new = (cur_class_q == ptd_pkg::CL_PER) ? ptd_pkg::ST_SUSPENDED
					: ptd_pkg::ST_READY;
			end
			ptd_pkg::OP_TERMINATE: cur_new = ptd_pkg::ST_DEAD;
			ptd_pkg::OP_BLOCK:     cur_new = ptd_pkg::ST_BLOCKED;
			default: begin
				cur_new = ptd_pkg::ST_DEAD;
				cur_upd = 1'b0;
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptd_pkg::FSM_IDLE: begin
				if (acc) begin
					state_d = (req.op <= ptd_pkg::OP_BLOCK) ? ptd_pkg::FSM_SYS
						: ptd_pkg::FSM_OUT;
				end
			end
			ptd_pkg::FSM_SYS: begin
				if (sys_hit) begin
					state_d = ptd_pkg::FSM_OUT;
				end else if (sys_last) begin
					state_d = ptd_pkg::FSM_PRD_RD;
				end
			end
			ptd_pkg::FSM_PRD_RD: begin
				if (per_live) begin
					state_d = ptd_pkg::FSM_PRD_EX;
				end else if (per_last) begin
					state_d = ptd_pkg::FSM_RR;
				end
			end
			ptd_pkg::FSM_PRD_EX: begin
				if (per_take) begin
					state_d = ptd_pkg::FSM_OUT;
				end else if (per_last) begin
					state_d = ptd_pkg::FSM_RR;
				end else begin
					state_d = ptd_pkg::FSM_PRD_RD;
				end
			end
			ptd_pkg::FSM_RR: begin
				if (rr_hit || rr_last) begin
					state_d = ptd_pkg::FSM_OUT;
				end
			end
			ptd_pkg::FSM_OUT: begin
				if (rsp_load) begin
					state_d = ptd_pkg::FSM_IDLE;
				end
			end
			default: state_d = ptd_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptd_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot states, pointers, current task and the event's result fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptd_pkg::SYS_SLOTS; i++) sys_st_q[i] <= ptd_pkg::ST_DEAD;
			for (int i = 0; i < ptd_pkg::RR_SLOTS; i++)  rr_st_q[i]  <= ptd_pkg::ST_DEAD;
			for (int i = 0; i < ptd_pkg::PER_SLOTS; i++) per_st_q[i] <= ptd_pkg::ST_DEAD;
			time_q      <= '0;
			sys_ptr_q   <= '0;
			per_ptr_q   <= '0;
			rr_ptr_q    <= '0;
			cur_class_q <= ptd_pkg::CL_IDLE;
			cur_slot_q  <= '0;
			cnt_q       <= '0;
			err_q       <= ptd_pkg::ERR_NONE;
			created_q   <= '0;
		end else begin
			case (state_q)
				ptd_pkg::FSM_IDLE: begin
					if (acc) begin
						cnt_q     <= '0;
						err_q     <= ptd_pkg::ERR_NONE;
						created_q <= '0;
						if (req.op == ptd_pkg::OP_TICK) begin
							time_q <= time_q + 16'd1;
						end
						if (cur_upd) begin
							case (cur_class_q)
								ptd_pkg::CL_SYS:
									sys_st_q[cur_slot_q[ptd_pkg::SYS_IW-1:0]] <= cur_new;
								ptd_pkg::CL_PER:
									per_st_q[cur_slot_q[ptd_pkg::PER_IW-1:0]] <= cur_new;
								ptd_pkg::CL_RR:
									rr_st_q[cur_slot_q[ptd_pkg::RR_IW-1:0]] <= cur_new;
								default: ;
							endcase
						end
						if (req.op == ptd_pkg::OP_CREATE && req.task_class != ptd_pkg::CL_IDLE) begin
							if (!dead_found) begin
								err_q <= ptd_pkg::ERR_FULL;
							end else begin
								created_q <= 3'(dead_idx);
								case (req.task_class)
									ptd_pkg::CL_SYS: sys_st_q[dead_idx[ptd_pkg::SYS_IW-1:0]]
										<= ptd_pkg::ST_READY;
									ptd_pkg::CL_PER: per_st_q[dead_idx[ptd_pkg::PER_IW-1:0]]
										<= ptd_pkg::ST_SUSPENDED;
									default: rr_st_q[dead_idx[ptd_pkg::RR_IW-1:0]]
										<= ptd_pkg::ST_READY;
								endcase
							end
						end
					end
				end
				ptd_pkg::FSM_SYS: begin
					if (sys_hit) begin
						sys_st_q[sys_ptr_q] <= ptd_pkg::ST_RUNNING;
						cur_class_q         <= ptd_pkg::CL_SYS;
						cur_slot_q          <= ptd_pkg::SLOT_W'(sys_ptr_q);
					end else begin
						sys_ptr_q <= sys_ptr_nx;
						cnt_q     <= sys_last ? '0 : cnt_q + 1'b1;
					end
				end
				ptd_pkg::FSM_PRD_RD: begin
					if (!per_live) begin
						per_ptr_q <= per_ptr_nx;
						cnt_q     <= per_last ? '0 : cnt_q + 1'b1;
					end
				end
				ptd_pkg::FSM_PRD_EX: begin
					if (per_take) begin
						per_st_q[per_ptr_q] <= ptd_pkg::ST_RUNNING;
						cur_class_q         <= ptd_pkg::CL_PER;
						cur_slot_q          <= ptd_pkg::SLOT_W'(per_ptr_q);
						if (per_st_p == ptd_pkg::ST_READY
							&& mem_rdata.run_ticks > mem_rdata.wcet) begin
							err_q <= ptd_pkg::ERR_WCET;
						end
					end else begin
						per_ptr_q <= per_ptr_nx;
						cnt_q     <= per_last ? '0 : cnt_q + 1'b1;
					end
				end
				ptd_pkg::FSM_RR: begin
					rr_ptr_q <= rr_ptr_nx;
					cnt_q    <= cnt_q + 1'b1;
					if (rr_hit) begin
						rr_st_q[rr_ptr_q] <= ptd_pkg::ST_RUNNING;
						cur_class_q       <= ptd_pkg::CL_RR;
						cur_slot_q        <= ptd_pkg::SLOT_W'(rr_ptr_q);
					end else if (rr_last) begin
						cur_class_q <= ptd_pkg::CL_IDLE;
						cur_slot_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q        <= 1'b1;
				rsp_q.run_class    <= cur_class_q;
				rsp_q.run_slot     <= 3'(cur_slot_q);
				rsp_q.error_code   <= err_q;
				rsp_q.created_slot <= created_q;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Running flags of all slots, for checking.
	always_comb begin
		for (int i = 0; i < ptd_pkg::SYS_SLOTS; i++)
			run_vec[i] = (sys_st_q[i] == ptd_pkg::ST_RUNNING);
		for (int i = 0; i < ptd_pkg::RR_SLOTS; i++)
			run_vec[ptd_pkg::SYS_SLOTS + i] = (rr_st_q[i] == ptd_pkg::ST_RUNNING);
		for (int i = 0; i < ptd_pkg::PER_SLOTS; i++)
			run_vec[ptd_pkg::SYS_SLOTS + ptd_pkg::RR_SLOTS + i] =
				(per_st_q[i] == ptd_pkg::ST_RUNNING);
	end

	// At most one task is running between events.
	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::FSM_IDLE |-> $onehot0(run_vec))
		else $error("more than one task running");

	// The current task is idle exactly when no slot is running.
	a_idle_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::FSM_IDLE |-> ((cur_class_q == ptd_pkg::CL_IDLE) == (run_vec == '0)))
		else $error("current task disagrees with slot states");

	// A record is used only in the cycle after its memory read.
	a_read_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::FSM_PRD_EX |-> $past(mem_re))
		else $error("periodic record used without a read");

	// The scan counter stays inside the periodic table.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptd_pkg::FSM_PRD_RD || state_q == ptd_pkg::FSM_PRD_EX)
		|-> cnt_q < ptd_pkg::CNT_W'(ptd_pkg::PER_SLOTS))
		else $error("periodic scan counter out of range");

endmodule

// ===== verif/priority_task_dispatcher_core_test.sv =====
// Self-checking testbench for the priority task dispatcher core.
`timescale 1ns / 1ps

module priority_task_dispatcher_core_test;

	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_EVENTS = 900;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ptd_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	ptd_pkg::rsp_t rsp;

	priority_task_dispatcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the dispatcher state.
	ptd_pkg::slot_st_t sys_st[ptd_pkg::SYS_SLOTS];
	ptd_pkg::slot_st_t rr_st[ptd_pkg::RR_SLOTS];
	ptd_pkg::slot_st_t per_st[ptd_pkg::PER_SLOTS];
	logic [15:0] per_period[ptd_pkg::PER_SLOTS];
	logic [15:0] per_wcet[ptd_pkg::PER_SLOTS];
	int per_count[ptd_pkg::PER_SLOTS];
	logic [15:0] per_last[ptd_pkg::PER_SLOTS];
	logic [15:0] per_runlen[ptd_pkg::PER_SLOTS];
	logic [15:0] now_ticks;
	int sys_ptr, per_ptr, rr_ptr;
	logic [1:0] cur_class;
	int cur_slot;

	ptd_pkg::rsp_t pending_rsp[$];
	int errors = 0;
	int events_sent = 0;
	int results_seen = 0;
	int wcet_hits = 0;
	int full_hits = 0;
	bit hold_rsp = 1'b0;

	// Bring a periodic record up to the present tick.
	function automatic void age_task(int p);
		logic [15:0] delta;
		int c;
		int r;
		delta = now_ticks - per_last[p];
		c = per_count[p] - int'(delta);
		r = int'(per_runlen[p]) + int'(delta);
		per_count[p] = (c < -65536) ? -65536 : c;
		per_last[p] = now_ticks;
		per_runlen[p] = (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	// Pick the next task in priority order; returns the error code.
	function automatic logic [1:0] pick_next_task();
		int s;
		logic [1:0] e;
		for (int i = 0; i < ptd_pkg::SYS_SLOTS; i++) begin
			s = sys_ptr;
			if (sys_st[s] == ptd_pkg::ST_READY) begin
				sys_st[s] = ptd_pkg::ST_RUNNING;
				cur_class = ptd_pkg::CL_SYS;
				cur_slot = s;
				return ptd_pkg::ERR_NONE;
			end
			sys_ptr = (s + 1) % ptd_pkg::SYS_SLOTS;
		end
		for (int i = 0; i < ptd_pkg::PER_SLOTS; i++) begin
			s = per_ptr;
			if (per_st[s] == ptd_pkg::ST_READY) begin
				e = (per_runlen[s] > per_wcet[s]) ? ptd_pkg::ERR_WCET : ptd_pkg::ERR_NONE;
				age_task(s);
				per_st[s] = ptd_pkg::ST_RUNNING;
				cur_class = ptd_pkg::CL_PER;
				cur_slot = s;
				return e;
			end
			if (per_st[s] == ptd_pkg::ST_SUSPENDED) begin
				age_task(s);
				if (per_count[s] <= 0) begin
					per_runlen[s] = 16'd1;
					per_count[s] = int'(per_period[s]);
					per_st[s] = ptd_pkg::ST_RUNNING;
					cur_class = ptd_pkg::CL_PER;
					cur_slot = s;
					return ptd_pkg::ERR_NONE;
				end
			end
			per_ptr = (s + 1) % ptd_pkg::PER_SLOTS;
		end
		for (int i = 0; i < ptd_pkg::RR_SLOTS; i++) begin
			s = rr_ptr;
			rr_ptr = (s + 1) % ptd_pkg::RR_SLOTS;
			if (rr_st[s] == ptd_pkg::ST_READY) begin
				rr_st[s] = ptd_pkg::ST_RUNNING;
				cur_class = ptd_pkg::CL_RR;
				cur_slot = s;
				return ptd_pkg::ERR_NONE;
			end
		end
		cur_class = ptd_pkg::CL_IDLE;
		cur_slot = 0;
		return ptd_pkg::ERR_NONE;
	endfunction

	function automatic void set_cur_state(ptd_pkg::slot_st_t v);
		case (cur_class)
			ptd_pkg::CL_SYS: sys_st[cur_slot] = v;
			ptd_pkg::CL_PER: per_st[cur_slot] = v;
			ptd_pkg::CL_RR: rr_st[cur_slot] = v;
			default: ;
		endcase
	endfunction

	function automatic ptd_pkg::slot_st_t get_cur_state();
		case (cur_class)
			ptd_pkg::CL_SYS: return sys_st[cur_slot];
			ptd_pkg::CL_PER: return per_st[cur_slot];
			ptd_pkg::CL_RR: return rr_st[cur_slot];
			default: return ptd_pkg::ST_DEAD;
		endcase
	endfunction

	// Apply one kernel event to the shadow state and return the result.
	function automatic ptd_pkg::rsp_t predict_event(ptd_pkg::req_t ev);
		ptd_pkg::rsp_t o;
		int x;
		int n;
		o = '0;
		case (ev.op)
			ptd_pkg::OP_TICK: begin
				now_ticks = now_ticks + 16'd1;
				if (cur_class != ptd_pkg::CL_IDLE && get_cur_state() == ptd_pkg::ST_RUNNING)
					set_cur_state(ptd_pkg::ST_READY);
				o.error_code = pick_next_task();
			end
			ptd_pkg::OP_YIELD: begin
				if (cur_class != ptd_pkg::CL_IDLE)
					set_cur_state(cur_class == ptd_pkg::CL_PER ? ptd_pkg::ST_SUSPENDED
						: ptd_pkg::ST_READY);
				o.error_code = pick_next_task();
			end
			ptd_pkg::OP_TERMINATE, ptd_pkg::OP_BLOCK: begin
				if (cur_class != ptd_pkg::CL_IDLE)
					set_cur_state(ev.op == ptd_pkg::OP_TERMINATE ? ptd_pkg::ST_DEAD
						: ptd_pkg::ST_BLOCKED);
				o.error_code = pick_next_task();
			end
			ptd_pkg::OP_CREATE: begin
				if (ev.task_class != ptd_pkg::CL_IDLE) begin
					n = (ev.task_class == ptd_pkg::CL_SYS) ? ptd_pkg::SYS_SLOTS :
						(ev.task_class == ptd_pkg::CL_PER) ? ptd_pkg::PER_SLOTS
						: ptd_pkg::RR_SLOTS;
					x = n;
					for (int i = n - 1; i >= 0; i--) begin
						if ((ev.task_class == ptd_pkg::CL_SYS && sys_st[i] == ptd_pkg::ST_DEAD) ||
							(ev.task_class == ptd_pkg::CL_PER && per_st[i] == ptd_pkg::ST_DEAD) ||
							(ev.task_class == ptd_pkg::CL_RR && rr_st[i] == ptd_pkg::ST_DEAD))
							x = i;
					end
					if (x >= n) begin
						o.error_code = ptd_pkg::ERR_FULL;
					end else begin
						o.created_slot = x[2:0];
						if (ev.task_class == ptd_pkg::CL_PER) begin
							per_period[x] = ev.period;
							per_wcet[x] = ev.wcet;
							per_count[x] = int'(ev.offset);
							per_last[x] = now_ticks;
							per_runlen[x] = 16'd0;
							per_st[x] = ptd_pkg::ST_SUSPENDED;
						end else if (ev.task_class == ptd_pkg::CL_SYS) begin
							sys_st[x] = ptd_pkg::ST_READY;
						end else begin
							rr_st[x] = ptd_pkg::ST_READY;
						end
					end
				end
			end
			default: ;
		endcase
		o.run_class = cur_class;
		o.run_slot = cur_slot[2:0];
		return o;
	endfunction

	// Send one event and record its expected result.
	task automatic send_event(ptd_pkg::req_t ev, bit typed_in, ptd_pkg::rsp_t typed_rsp);
		ptd_pkg::rsp_t p;
		p = predict_event(ev);
		if (typed_in && p !== typed_rsp) begin
			$error("directed row disagrees with prediction: %h vs %h", typed_rsp, p);
			errors++;
		end
		req <= ev;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(typed_in ? typed_rsp : p);
		events_sent++;
	endtask

	task automatic drop_valid();
		req_valid <= 1'b0;
	endtask

	function automatic ptd_pkg::req_t make_event(logic [2:0] op, logic [1:0] cls,
		logic [15:0] per, logic [15:0] wc, logic [14:0] off);
		ptd_pkg::req_t r;
		r.op = op;
		r.task_class = cls;
		r.period = per;
		r.wcet = wc;
		r.offset = off;
		return r;
	endfunction

	// Random event, biased toward ticks and creates so tasks stay alive.
	function automatic ptd_pkg::req_t random_event();
		ptd_pkg::req_t r;
		int k;
		r.period = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		r.wcet = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		r.offset = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 8));
		r.task_class = 2'($urandom_range(0, 3));
		k = $urandom_range(0, 99);
		if (k < 40) r.op = ptd_pkg::OP_TICK;
		else if (k < 55) r.op = ptd_pkg::OP_YIELD;
		else if (k < 63) r.op = ptd_pkg::OP_TERMINATE;
		else if (k < 67) r.op = ptd_pkg::OP_BLOCK;
		else if (k < 97) r.op = ptd_pkg::OP_CREATE;
		else r.op = 3'($urandom_range(5, 7));
		// Block kills slots for good; reset of the shadow is not possible, so keep it rare.
		return r;
	endfunction

	typedef struct {
		ptd_pkg::req_t ev;
		bit typed_in;
		ptd_pkg::rsp_t rsp;
	} stim_row_t;

	stim_row_t stim_rows[$];

	function automatic ptd_pkg::rsp_t r4(logic [1:0] c, logic [2:0] s, logic [1:0] e,
		logic [2:0] k);
		ptd_pkg::rsp_t o;
		o.run_class = c;
		o.run_slot = s;
		o.error_code = e;
		o.created_slot = k;
		return o;
	endfunction

	function automatic void add_row(ptd_pkg::req_t ev, bit t, ptd_pkg::rsp_t o);
		stim_row_t row;
		row.ev = ev;
		row.typed_in = t;
		row.rsp = o;
		stim_rows.push_back(row);
	endfunction

	// Directed table: idle events, extremes of fields, full classes, WCET overrun.
	function automatic void build_table();
		add_row(make_event(ptd_pkg::OP_TICK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(ptd_pkg::OP_YIELD, ptd_pkg::CL_IDLE, 16'hFFFF, 16'hFFFF, 15'h7FFF),
			1'b1, r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(ptd_pkg::OP_TERMINATE, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(ptd_pkg::OP_BLOCK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(3'd7, ptd_pkg::CL_SYS, 16'h0, 16'h0, 15'h0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(ptd_pkg::OP_CREATE, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		// A periodic task that overruns its zero WCET.
		add_row(make_event(ptd_pkg::OP_CREATE, ptd_pkg::CL_PER, 16'd0, 16'd0, 15'd0), 1'b1,
			r4(ptd_pkg::CL_IDLE, 3'd0, ptd_pkg::ERR_NONE, 3'd0));
		add_row(make_event(ptd_pkg::OP_TICK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(ptd_pkg::OP_TICK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(ptd_pkg::OP_TICK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(ptd_pkg::OP_CREATE, ptd_pkg::CL_PER, 16'hFFFF, 16'hFFFF, 15'h7FFF),
			1'b1, r4(ptd_pkg::CL_PER, 3'd0, ptd_pkg::ERR_NONE, 3'd1));
		for (int i = 0; i < 5; i++)
			add_row(make_event(ptd_pkg::OP_CREATE, ptd_pkg::CL_SYS, 16'h0, 16'h0, 15'h0), 1'b1,
				r4(ptd_pkg::CL_PER, 3'd0, i < 4 ? ptd_pkg::ERR_NONE : ptd_pkg::ERR_FULL,
				i < 4 ? 3'(i) : 3'd0));
		for (int i = 0; i < 5; i++)
			add_row(make_event(ptd_pkg::OP_CREATE, ptd_pkg::CL_RR, 16'h0, 16'h0, 15'h0), 1'b1,
				r4(ptd_pkg::CL_PER, 3'd0, i < 4 ? ptd_pkg::ERR_NONE : ptd_pkg::ERR_FULL,
				i < 4 ? 3'(i) : 3'd0));
		add_row(make_event(ptd_pkg::OP_YIELD, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(ptd_pkg::OP_TERMINATE, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0,
			'0);
		add_row(make_event(ptd_pkg::OP_BLOCK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(ptd_pkg::OP_TICK, ptd_pkg::CL_IDLE, 16'h0, 16'h0, 15'h0), 1'b0, '0);
		add_row(make_event(3'd5, ptd_pkg::CL_RR, 16'h0, 16'h0, 15'h0), 1'b0, '0);
	endfunction

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				$error("result transfer with nothing expected: %h", rsp);
				errors++;
			end else begin
				ptd_pkg::rsp_t want;
				want = pending_rsp.pop_front();
				if (want.error_code == ptd_pkg::ERR_WCET) wcet_hits++;
				if (want.error_code == ptd_pkg::ERR_FULL) full_hits++;
				if (rsp.run_class !== want.run_class) begin
					$error("run_class expected %0d actual %0d", want.run_class, rsp.run_class);
					errors++;
				end
				if (rsp.run_slot !== want.run_slot) begin
					$error("run_slot expected %0d actual %0d", want.run_slot, rsp.run_slot);
					errors++;
				end
				if (rsp.error_code !== want.error_code) begin
					$error("error_code expected %0d actual %0d", want.error_code,
						rsp.error_code);
					errors++;
				end
				if (rsp.created_slot !== want.created_slot) begin
					$error("created_slot expected %0d actual %0d", want.created_slot,
						rsp.created_slot);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int phase;
		rsp_stall = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end else if ((phase / 200) % 3 == 0) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("priority_task_dispatcher_core verification failed");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int burst;
		int gap;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < ptd_pkg::SYS_SLOTS; i++) sys_st[i] = ptd_pkg::ST_DEAD;
		for (int i = 0; i < ptd_pkg::RR_SLOTS; i++) rr_st[i] = ptd_pkg::ST_DEAD;
		for (int i = 0; i < ptd_pkg::PER_SLOTS; i++) begin
			per_st[i] = ptd_pkg::ST_DEAD;
			per_period[i] = '0;
			per_wcet[i] = '0;
			per_count[i] = 0;
			per_last[i] = '0;
			per_runlen[i] = '0;
		end
		now_ticks = '0;
		sys_ptr = 0;
		per_ptr = 0;
		rr_ptr = 0;
		cur_class = ptd_pkg::CL_IDLE;
		cur_slot = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_table();
		foreach (stim_rows[i])
			send_event(stim_rows[i].ev, stim_rows[i].typed_in, stim_rows[i].rsp);
		drop_valid();

		// Pause until the dispatcher has drained.
		while (pending_rsp.size() != 0) @(posedge clk);

		// Long receiver hold-off while events keep coming.
		hold_rsp = 1'b1;
		for (int i = 0; i < 6; i++)
			send_event(random_event(), 1'b0, '0);

		burst = 0;
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
				if (gap > 0) begin
					drop_valid();
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 20);
			end
			send_event(random_event(), 1'b0, '0);
			burst--;
		end
		drop_valid();

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d kernel events and checked %0d results.", events_sent,
			results_seen);
		$display("Class-full errors: %0d, WCET overruns: %0d.", full_hits, wcet_hits);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("priority_task_dispatcher_core verification clean");
		else
			$display("priority_task_dispatcher_core verification failed");
		$finish;
	end

endmodule

// ===== priority_task_dispatcher_core.f =====
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_pmem.sv
hw/rtl/priority_task_dispatcher_core.sv
verif/priority_task_dispatcher_core_test.sv
